[hw/rtl/lirs_pkg.sv]
// Shared types, constants and microcode ROM for the linear interpolation resampler.
`default_nettype none

package lirs_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 19;

  // Sequencer step addresses; the step address is the sequencer state.
  typedef enum logic [2:0] {
    STEP_FETCH  = 3'd0,
    STEP_CHECK  = 3'd1,
    STEP_TEST   = 3'd2,
    STEP_EMIT   = 3'd3,
    STEP_FINISH = 3'd4,
    STEP_PRIME  = 3'd5
  } step_t;

  // Jump conditions that a control word can test.
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_NOT_PRIMED,
    COND_LOOP_DONE,
    COND_OUT_BUSY
  } cond_t;

  // One control word: datapath strobes, a jump condition and two addresses.
  typedef struct packed {
    logic  take_in;
    logic  mul_en;
    logic  emit;
    logic  finish;
    logic  prime;
    cond_t cond;
    step_t jump_addr;
    step_t next_addr;
  } ctrl_t;

  // Microcode ROM: one control word per step.
  function automatic ctrl_t ucode_rom(input step_t addr);
    ctrl_t w;
    w = '{take_in: 1'b0, mul_en: 1'b0, emit: 1'b0, finish: 1'b0, prime: 1'b0,
          cond: COND_ALWAYS, jump_addr: STEP_FETCH, next_addr: STEP_FETCH};
    case (addr)
      STEP_FETCH: begin
        w.take_in   = 1'b1;
        w.cond      = COND_NO_INPUT;
        w.jump_addr = STEP_FETCH;
        w.next_addr = STEP_CHECK;
      end
      STEP_CHECK: begin
        w.cond      = COND_NOT_PRIMED;
        w.jump_addr = STEP_PRIME;
        w.next_addr = STEP_TEST;
      end
      STEP_TEST: begin
        w.mul_en    = 1'b1;
        w.cond      = COND_LOOP_DONE;
        w.jump_addr = STEP_FINISH;
        w.next_addr = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit      = 1'b1;
        w.cond      = COND_OUT_BUSY;
        w.jump_addr = STEP_EMIT;
        w.next_addr = STEP_TEST;
      end
      STEP_FINISH: begin
        w.finish    = 1'b1;
      end
      STEP_PRIME: begin
        w.prime     = 1'b1;
      end
      default: begin
        w.cond      = COND_ALWAYS;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/linear_interp_resampler.sv]
// Linear interpolation sample rate converter, driven by a microcoded sequencer.
//
// Usage: one signed 16-bit sample is taken per input transfer (in_valid/in_ready).
// Each sample causes zero to MAX_UPSAMPLE output transfers (out_valid/out_ready),
// each an interpolated, rounded and saturated sample; last marks the final one
// caused by that input. The first sample after reset only primes the block.
// The phase increment step (input rate over output rate, unsigned Q.FRAC_BITS)
// is written through cfg_wr_en/cfg_wr_data while the block is idle.
// Sequence: after its transfer a sample passes the check step, then a test/multiply
// step and an emit step of the sequencer for each result it causes, then a last test
// step and the finish step, and the sequencer is back at the fetch step. The first
// result enters the output register in the first emit step. The sequencer works on
// one sample at a time; the next sample can be taken while the last result still
// sits in the output register, if the receiver has not yet taken it.
// Reset clears the sequencer, the output valid flag, the phase, the primed flag,
// the previous sample and the result counter, and sets step to 1.0.
// When the receiver stalls, the emit step waits until the output register frees.
`default_nettype none

module linear_interp_resampler
  import lirs_pkg::*;
#(
  parameter int FRAC_BITS    = 15,
  parameter int MAX_UPSAMPLE = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [PHASE_W-1:0]         cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      out_sample,
  output logic                            last
);

  localparam int CNT_W  = $clog2(MAX_UPSAMPLE + 1);
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam int ACC_W  = PROD_W + 1;
  localparam logic [PHASE_W-1:0] ONE_Q     = PHASE_W'(1 << FRAC_BITS);
  localparam logic [PHASE_W-1:0] PHASE_MAX = {PHASE_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_UPSAMPLE);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [ACC_W-FRAC_BITS-1:0] SAT_HI = (ACC_W-FRAC_BITS)'(32767);
  localparam logic signed [ACC_W-FRAC_BITS-1:0] SAT_LO = -(ACC_W-FRAC_BITS)'(32768);

  // Sequencer and datapath registers.
  step_t                      upc, upc_next;
  logic [PHASE_W-1:0]         step;
  logic [PHASE_W-1:0]         phase;
  logic                       primed;
  logic signed [SAMPLE_W-1:0] prev_sample;
  logic signed [SAMPLE_W-1:0] cur_sample;
  logic [CNT_W-1:0]           n_cnt;
  logic signed [PROD_W-1:0]   prod;

  ctrl_t                      ctrl;
  logic                       cond_true;
  logic                       out_busy;
  logic                       in_xfer;
  logic                       emit_fire;
  logic                       loop_done;
  logic [PHASE_W:0]           phase_sum;
  logic [PHASE_W-1:0]         phase_adv;
  logic [CNT_W-1:0]           n_inc;
  logic                       last_flag;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [FRAC_BITS:0]  frac_s;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-FRAC_BITS-1:0] shifted;
  logic signed [SAMPLE_W-1:0] result;

  // Control word of the current step.
  assign ctrl = ucode_rom(upc);

  // Status flags tested by the microcode.
  assign out_busy  = out_valid && !out_ready;
  assign loop_done = (phase >= ONE_Q) || (n_cnt == CNT_MAX);

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:     cond_true = 1'b1;
      COND_NO_INPUT:   cond_true = !in_valid;
      COND_NOT_PRIMED: cond_true = !primed;
      COND_LOOP_DONE:  cond_true = loop_done;
      COND_OUT_BUSY:   cond_true = out_busy;
      default:         cond_true = 1'b1;
    endcase
  end

  // Next step address.
  always_comb begin
    upc_next = cond_true ? ctrl.jump_addr : ctrl.next_addr;
  end

  // Strobes derived from the control word.
  always_comb begin
    in_ready  = ctrl.take_in;
    in_xfer   = in_valid && ctrl.take_in;
    emit_fire = ctrl.emit && !out_busy;
  end

  // Phase advance with saturation, and the end-of-burst flag for this result.
  assign phase_sum = {1'b0, phase} + {1'b0, step};
  assign phase_adv = phase_sum[PHASE_W] ? PHASE_MAX : phase_sum[PHASE_W-1:0];
  assign n_inc     = n_cnt + 1'b1;
  assign last_flag = (phase_adv >= ONE_Q) || (n_inc == CNT_MAX);

  // Interpolation: prev + (cur - prev) * frac, with the product registered.
  assign diff   = DIFF_W'(cur_sample) - DIFF_W'(prev_sample);
  assign frac_s = signed'({1'b0, phase[FRAC_BITS-1:0]});
  assign acc    = (ACC_W'(prev_sample) <<< FRAC_BITS) + ACC_W'(prod) + HALF;
  assign shifted = acc[ACC_W-1:FRAC_BITS];

  // Saturate to the sample range.
  always_comb begin
    if (shifted > SAT_HI) begin
      result = SAMPLE_W'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      result = SAMPLE_W'(SAT_LO);
    end else begin
      result = shifted[SAMPLE_W-1:0];
    end
  end

  // Sequencer step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ONE_Q;
    end else if (cfg_wr_en) begin
      step <= cfg_wr_data;
    end
  end

  // Sample, phase and result counter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      primed      <= 1'b0;
      prev_sample <= '0;
      n_cnt       <= '0;
    end else begin
      if (emit_fire) begin
        phase <= phase_adv;
        n_cnt <= n_inc;
      end
      if (ctrl.finish) begin
        phase       <= (phase >= ONE_Q) ? (phase - ONE_Q) : '0;
        prev_sample <= cur_sample;
        n_cnt       <= '0;
      end
      if (ctrl.prime) begin
        prev_sample <= cur_sample;
        primed      <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_sample <= sample;
    end
    if (ctrl.mul_en) begin
      prod <= diff * frac_s;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_sample <= result;
      last       <= last_flag;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lirs_checker.sv]
// Port-level checker for the linear interpolation resampler, with its bind.
`default_nettype none

module lirs_checker
  import lirs_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic signed [SAMPLE_W-1:0] out_sample,
  input wire logic                       last
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(last))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // One sample at a time: after an input transfer the block is busy.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // A result never appears in the cycle right after an input transfer.
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result too early after input");

endmodule

bind linear_interp_resampler lirs_checker u_lirs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_sample (out_sample),
  .last       (last)
);

`default_nettype wire
